// ===== src/countdown_timer_bank_top_macros.svh =====
`ifndef COUNTDOWN_TIMER_BANK_TOP_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("countdown timer bank: same-cycle check failed");

// next-cycle implication, disabled in reset
`define CTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("countdown timer bank: next-cycle check failed");

`endif

// ===== src/ctb_pkg.sv =====
package ctb_pkg;

   localparam int NUM_TIMERS    = 8;
   localparam int COUNT_WIDTH   = 32;
   localparam int DIGIT_WIDTH   = 8;
   localparam int NUM_DIGITS    = (COUNT_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int PAD_WIDTH     = NUM_DIGITS * DIGIT_WIDTH;
   localparam int IDX_WIDTH     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int DIG_CNT_WIDTH = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam int COMMAND_WIDTH = 2;
   localparam int INDEX_WIDTH   = 3;
   localparam int VALUE_WIDTH   = 32;
   localparam int MASK_WIDTH    = 8;
   localparam int TALLY_WIDTH   = 16;
   localparam int OUT_WIDTH     = 32;
   localparam int MASK_LANES    = (NUM_TIMERS < MASK_WIDTH) ? NUM_TIMERS : MASK_WIDTH;

   typedef logic [COMMAND_WIDTH-1:0] command_type;
   typedef logic [IDX_WIDTH-1:0]     index_type;
   typedef logic [DIG_CNT_WIDTH-1:0] digit_cnt_type;
   typedef logic [DIGIT_WIDTH-1:0]   digit_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;
   typedef logic [PAD_WIDTH-1:0]     shift_type;
   typedef logic [TALLY_WIDTH-1:0]   tally_type;
   typedef logic [OUT_WIDTH-1:0]     count_out_type;
   typedef logic [MASK_WIDTH-1:0]    mask_type;

   localparam command_type CMD_TICK = 2'd0;
   localparam command_type CMD_ADD  = 2'd1;
   localparam command_type CMD_LOAD = 2'd2;
   localparam command_type CMD_READ = 2'd3;

   // per-lane results gathered while the digits go by
   typedef struct packed {
      logic nz;       // counter nonzero
      logic one;      // counter equals one so far
      logic pend_nz;  // queued load nonzero
      logic borrow;   // decrement borrow into the next digit
   } lane_flags_type;

   // drop the low digit, insert a new digit at the top
   function automatic shift_type shift_digit(shift_type x, digit_type d);
      shift_type r;
      r = (x >> DIGIT_WIDTH) | (shift_type'(d) << (PAD_WIDTH - DIGIT_WIDTH));
      return r;
   endfunction

endpackage

// ===== src/countdown_timer_bank_top.sv =====
// channel   ports                                   handshake
// request   req_command, req_timer_index, req_value  start high while busy low
// response  rsp_expired_mask, rsp_expiry_tally,      rsp_valid strobe, one cycle
//           rsp_count_now, rsp_is_active
//
// Add, load and read act in the cycle they are accepted; the response word follows in the next cycle.
// A tick runs all timers in parallel lanes, one 8-bit digit per cycle, a scan pass
// then an update pass.
// Synchronous reset clears every timer and leaves the block idle.
// The response cannot be stalled; busy alone holds off requests.
`include "countdown_timer_bank_top_macros.svh"

module countdown_timer_bank_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ctb_pkg::COMMAND_WIDTH-1:0] req_command,
   input  logic [ctb_pkg::INDEX_WIDTH-1:0]   req_timer_index,
   input  logic [ctb_pkg::VALUE_WIDTH-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [ctb_pkg::MASK_WIDTH-1:0]    rsp_expired_mask,
   output logic [ctb_pkg::TALLY_WIDTH-1:0]   rsp_expiry_tally,
   output logic [ctb_pkg::OUT_WIDTH-1:0]     rsp_count_now,
   output logic                          rsp_is_active
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   ctb_pkg::digit_cnt_type digit_ff, digit_in;

   ctb_pkg::shift_type ctr_ff  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::shift_type ctr_in  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::shift_type rpt_ff  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::shift_type rpt_in  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::shift_type pend_ff [ctb_pkg::NUM_TIMERS];
   ctb_pkg::shift_type pend_in [ctb_pkg::NUM_TIMERS];
   ctb_pkg::tally_type tally_ff[ctb_pkg::NUM_TIMERS];
   ctb_pkg::tally_type tally_in[ctb_pkg::NUM_TIMERS];
   logic [ctb_pkg::NUM_TIMERS-1:0] active_ff, active_in;
   ctb_pkg::lane_flags_type flags_ff[ctb_pkg::NUM_TIMERS];
   ctb_pkg::lane_flags_type flags_in[ctb_pkg::NUM_TIMERS];

   logic                    rsp_valid_ff, rsp_valid_in;
   ctb_pkg::mask_type       mask_ff, mask_in;
   ctb_pkg::tally_type      out_tally_ff, out_tally_in;
   ctb_pkg::count_out_type  out_count_ff, out_count_in;
   logic                    out_active_ff, out_active_in;

   logic                accept;
   logic                in_range;
   logic                last_digit;
   ctb_pkg::index_type  sel;
   ctb_pkg::shift_type  val_cut;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start & ~busy;
   assign in_range   = (int'(req_timer_index) < ctb_pkg::NUM_TIMERS);
   assign sel        = ctb_pkg::index_type'(req_timer_index);
   assign val_cut    = ctb_pkg::shift_type'(ctb_pkg::count_type'(req_value));
   assign last_digit = (digit_ff == ctb_pkg::digit_cnt_type'(ctb_pkg::NUM_DIGITS - 1));

   always_comb begin
      ctb_pkg::digit_type d;
      ctb_pkg::digit_type p;
      ctb_pkg::digit_type r;
      ctb_pkg::digit_type nd;
      logic [ctb_pkg::DIGIT_WIDTH:0] diff;
      logic fire;

      state_in      = state_ff;
      digit_in      = digit_ff;
      ctr_in        = ctr_ff;
      rpt_in        = rpt_ff;
      pend_in       = pend_ff;
      tally_in      = tally_ff;
      active_in     = active_ff;
      flags_in      = flags_ff;
      rsp_valid_in  = 1'b0;
      mask_in       = mask_ff;
      out_tally_in  = out_tally_ff;
      out_count_in  = out_count_ff;
      out_active_in = out_active_ff;
      d    = '0;
      p    = '0;
      r    = '0;
      nd   = '0;
      diff = '0;
      fire = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == ctb_pkg::CMD_TICK) begin
                  state_in = ST_SCAN;
                  digit_in = '0;
                  for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
                     flags_in[i] = '{nz: 1'b0, one: 1'b0, pend_nz: 1'b0, borrow: 1'b1};
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  mask_in       = '0;
                  out_tally_in  = '0;
                  out_count_in  = '0;
                  out_active_in = 1'b0;
                  if (in_range) begin
                     case (req_command)
                        ctb_pkg::CMD_ADD: begin
                           rpt_in[sel]    = val_cut;
                           ctr_in[sel]    = val_cut;
                           tally_in[sel]  = '0;
                           pend_in[sel]   = '0;
                           active_in[sel] = 1'b1;
                        end
                        ctb_pkg::CMD_LOAD: begin
                           pend_in[sel] = val_cut;
                        end
                        default: begin
                        end
                     endcase
                     out_tally_in  = tally_in[sel];
                     out_count_in  = ctb_pkg::count_out_type'(ctr_in[sel]);
                     out_active_in = active_in[sel];
                  end
               end
            end
         end

         ST_SCAN: begin
            // rotate counter and queued load, gather flags
            for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
               d = ctr_ff[i][ctb_pkg::DIGIT_WIDTH-1:0];
               p = pend_ff[i][ctb_pkg::DIGIT_WIDTH-1:0];
               flags_in[i].nz      = flags_ff[i].nz | (d != '0);
               flags_in[i].pend_nz = flags_ff[i].pend_nz | (p != '0);
               if (digit_ff == '0) begin
                  flags_in[i].one = (d == ctb_pkg::digit_type'(1));
               end else begin
                  flags_in[i].one = flags_ff[i].one & (d == '0);
               end
               ctr_in[i]  = ctb_pkg::shift_digit(ctr_ff[i], d);
               pend_in[i] = ctb_pkg::shift_digit(pend_ff[i], p);
            end
            digit_in = digit_ff + 1'b1;
            if (last_digit) begin
               state_in = ST_UPDATE;
               digit_in = '0;
            end
         end

         ST_UPDATE: begin
            for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
               d    = ctr_ff[i][ctb_pkg::DIGIT_WIDTH-1:0];
               p    = pend_ff[i][ctb_pkg::DIGIT_WIDTH-1:0];
               r    = rpt_ff[i][ctb_pkg::DIGIT_WIDTH-1:0];
               diff = {1'b0, d} - {{ctb_pkg::DIGIT_WIDTH{1'b0}}, flags_ff[i].borrow};
               flags_in[i].borrow = diff[ctb_pkg::DIGIT_WIDTH];
               if (active_ff[i] & flags_ff[i].pend_nz) begin
                  nd = p;
               end else if (active_ff[i] & flags_ff[i].one) begin
                  nd = r;
               end else if (active_ff[i] & flags_ff[i].nz) begin
                  nd = diff[ctb_pkg::DIGIT_WIDTH-1:0];
               end else begin
                  nd = d;
               end
               ctr_in[i] = ctb_pkg::shift_digit(ctr_ff[i], nd);
               rpt_in[i] = ctb_pkg::shift_digit(rpt_ff[i], r);
               // consume the queued load as it goes out
               if (active_ff[i] & flags_ff[i].pend_nz) begin
                  pend_in[i] = ctb_pkg::shift_digit(pend_ff[i], '0);
               end else begin
                  pend_in[i] = ctb_pkg::shift_digit(pend_ff[i], p);
               end
               if (last_digit & active_ff[i] & flags_ff[i].one) begin
                  tally_in[i] = tally_ff[i] + 1'b1;
               end
            end
            digit_in = digit_ff + 1'b1;
            if (last_digit) begin
               state_in      = ST_IDLE;
               digit_in      = '0;
               rsp_valid_in  = 1'b1;
               mask_in       = '0;
               out_tally_in  = '0;
               out_count_in  = '0;
               out_active_in = 1'b0;
               for (int m = 0; m < ctb_pkg::MASK_LANES; m++) begin
                  fire       = active_ff[m] & flags_ff[m].one;
                  mask_in[m] = fire;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
            digit_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         digit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
            ctr_ff[i]   <= '0;
            rpt_ff[i]   <= '0;
            pend_ff[i]  <= '0;
            tally_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         ctr_ff       <= ctr_in;
         rpt_ff       <= rpt_in;
         pend_ff      <= pend_in;
         tally_ff     <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff      <= flags_in;
      mask_ff       <= mask_in;
      out_tally_ff  <= out_tally_in;
      out_count_ff  <= out_count_in;
      out_active_ff <= out_active_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_mask = mask_ff;
   assign rsp_expiry_tally = out_tally_ff;
   assign rsp_count_now    = out_count_ff;
   assign rsp_is_active    = out_active_ff;

   `CTB_ASSERT_NEXT(a_cmd_responds, clock, reset,
      accept && (req_command != ctb_pkg::CMD_TICK), rsp_valid)
   `CTB_ASSERT_NEXT(a_tick_responds, clock, reset,
      (state_ff == ST_UPDATE) && last_digit, rsp_valid && (state_ff == ST_IDLE))
   `CTB_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `CTB_ASSERT_NEXT(a_scan_to_update, clock, reset,
      (state_ff == ST_SCAN) && last_digit, (state_ff == ST_UPDATE) && (digit_ff == '0))
   `CTB_ASSERT_IMPL(a_mask_only_on_tick, clock, reset,
      rsp_valid && (rsp_expired_mask != '0),
      (rsp_expiry_tally == '0) && (rsp_count_now == '0) && !rsp_is_active)

endmodule

// ===== tb/tb.sv =====
module tb;

   typedef struct packed {
      ctb_pkg::command_type   cmd;
      logic [2:0]             idx;
      ctb_pkg::mask_type      mask;
      ctb_pkg::tally_type     tally;
      ctb_pkg::count_out_type count;
      logic                   active;
   } timer_word_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [ctb_pkg::COMMAND_WIDTH-1:0] req_command;
   logic [ctb_pkg::INDEX_WIDTH-1:0]   req_timer_index;
   logic [ctb_pkg::VALUE_WIDTH-1:0]   req_value;
   logic                              rsp_valid;
   logic [ctb_pkg::MASK_WIDTH-1:0]    rsp_expired_mask;
   logic [ctb_pkg::TALLY_WIDTH-1:0]   rsp_expiry_tally;
   logic [ctb_pkg::OUT_WIDTH-1:0]     rsp_count_now;
   logic                              rsp_is_active;

   // predicted bank state
   ctb_pkg::count_type counts  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::count_type repeats [ctb_pkg::NUM_TIMERS];
   ctb_pkg::count_type queued  [ctb_pkg::NUM_TIMERS];
   ctb_pkg::tally_type tallies [ctb_pkg::NUM_TIMERS];
   logic               armed   [ctb_pkg::NUM_TIMERS];

   timer_word_type timer_words_due[$];
   int mismatches = 0;
   int n_ticks = 0, n_adds = 0, n_loads = 0, n_reads = 0, n_expiries = 0;
   int burst_left = 0;

   countdown_timer_bank_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_timer_index  (req_timer_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_expired_mask (rsp_expired_mask),
      .rsp_expiry_tally (rsp_expiry_tally),
      .rsp_count_now    (rsp_count_now),
      .rsp_is_active    (rsp_is_active)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic timer_word_type bank_response(ctb_pkg::command_type cmd, int idx,
                                                    ctb_pkg::count_type val);
      timer_word_type w;
      w = '0;
      w.cmd = cmd;
      w.idx = idx[2:0];
      if (cmd == ctb_pkg::CMD_TICK) begin
         for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
            if (armed[i]) begin
               if (counts[i] != '0) begin
                  counts[i] = counts[i] - 1'b1;
                  if (counts[i] == '0) begin
                     tallies[i] = tallies[i] + 1'b1;
                     if (i < ctb_pkg::MASK_WIDTH) w.mask[i] = 1'b1;
                     if (repeats[i] != '0) counts[i] = repeats[i];
                  end
               end
               // a queued count overrides whatever the decrement left
               if (queued[i] != '0) begin
                  counts[i] = queued[i];
                  queued[i] = '0;
               end
            end
         end
         return w;
      end
      if (idx >= ctb_pkg::NUM_TIMERS) return w;
      case (cmd)
         ctb_pkg::CMD_ADD: begin
            repeats[idx] = val;
            counts[idx]  = val;
            tallies[idx] = '0;
            queued[idx]  = '0;
            armed[idx]   = 1'b1;
         end
         ctb_pkg::CMD_LOAD: queued[idx] = val;
         default: ;
      endcase
      w.tally  = tallies[idx];
      w.count  = ctb_pkg::count_out_type'(counts[idx]);
      w.active = armed[idx];
      return w;
   endfunction

   task automatic send_word(ctb_pkg::command_type cmd, logic [2:0] idx, logic [31:0] val);
      int gap;
      timer_word_type w;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         // junk on the request ports while start is low
         repeat (gap) begin
            req_command     <= ctb_pkg::command_type'($urandom);
            req_timer_index <= 3'($urandom);
            req_value       <= $urandom;
            @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
      start           <= 1'b1;
      req_command     <= cmd;
      req_timer_index <= idx;
      req_value       <= val;
      do @(posedge clock); while (busy !== 1'b0);
      w = bank_response(cmd, idx, ctb_pkg::count_type'(val));
      timer_words_due.push_back(w);
      case (cmd)
         ctb_pkg::CMD_TICK: begin
            n_ticks++;
            n_expiries += $countones(w.mask);
         end
         ctb_pkg::CMD_ADD:  n_adds++;
         ctb_pkg::CMD_LOAD: n_loads++;
         default:           n_reads++;
      endcase
   endtask

   always @(posedge clock) begin : check_words
      timer_word_type w;
      if (!reset && rsp_valid === 1'b1) begin
         if (timer_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: mask=%h tally=%h count=%h active=%b",
                        rsp_expired_mask, rsp_expiry_tally, rsp_count_now, rsp_is_active);
         end else begin
            w = timer_words_due.pop_front();
            if (rsp_expired_mask !== w.mask || rsp_expiry_tally !== w.tally ||
                rsp_count_now !== w.count || rsp_is_active !== w.active) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch cmd=%0d timer=%0d: expected mask=%h tally=%h count=%h active=%b",
                           w.cmd, w.idx, w.mask, w.tally, w.count, w.active);
                  $display("   got mask=%h tally=%h count=%h active=%b",
                           rsp_expired_mask, rsp_expiry_tally, rsp_count_now, rsp_is_active);
               end
            end
         end
      end
   end

   task automatic test_directed_cases();
      send_word(ctb_pkg::CMD_READ, 3'd0, 32'd0);
      // load into a timer that was never added
      send_word(ctb_pkg::CMD_LOAD, 3'd7, 32'd5);
      send_word(ctb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_word(ctb_pkg::CMD_ADD,  3'd7, 32'hFFFF_FFFF);
      send_word(ctb_pkg::CMD_ADD,  3'd0, 32'd1);
      send_word(ctb_pkg::CMD_ADD,  3'd1, 32'h0000_0100);
      send_word(ctb_pkg::CMD_ADD,  3'd2, 32'd2);
      send_word(ctb_pkg::CMD_LOAD, 3'd2, 32'd9);
      send_word(ctb_pkg::CMD_LOAD, 3'd2, 32'd0);
      send_word(ctb_pkg::CMD_ADD,  3'd3, 32'd0);
      send_word(ctb_pkg::CMD_LOAD, 3'd3, 32'd3);
      send_word(ctb_pkg::CMD_TICK, 3'd5, 32'hFFFF_FFFF);
      send_word(ctb_pkg::CMD_TICK, 3'd2, 32'h1234_5678);
      send_word(ctb_pkg::CMD_READ, 3'd1, 32'd0);
      send_word(ctb_pkg::CMD_READ, 3'd7, 32'd0);
      // re-add an active timer
      send_word(ctb_pkg::CMD_ADD,  3'd2, 32'h8000_0000);
      // expiry without repeat, count enters through a load
      send_word(ctb_pkg::CMD_ADD,  3'd4, 32'd0);
      send_word(ctb_pkg::CMD_LOAD, 3'd4, 32'd1);
      send_word(ctb_pkg::CMD_ADD,  3'd5, 32'h0001_0000);
      send_word(ctb_pkg::CMD_ADD,  3'd6, 32'h0100_0000);
      send_word(ctb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_word(ctb_pkg::CMD_LOAD, 3'd0, 32'd7);
      send_word(ctb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_word(ctb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_word(ctb_pkg::CMD_READ, 3'd4, 32'd0);
      send_word(ctb_pkg::CMD_READ, 3'd6, 32'd0);
   endtask

   function automatic logic [31:0] pick_count();
      int k;
      k = $urandom_range(8, 31);
      case ($urandom_range(0, 9))
         7:       return (32'd1 << k) - $urandom_range(0, 1);
         8:       return $urandom;
         9:       return $urandom_range(0, 40);
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   task automatic test_random_traffic();
      int r;
      logic [2:0] idx;
      repeat (600) begin
         r   = $urandom_range(0, 99);
         idx = 3'($urandom_range(0, 7));
         if (r < 45)      send_word(ctb_pkg::CMD_TICK, idx, $urandom);
         else if (r < 60) send_word(ctb_pkg::CMD_ADD,  idx, pick_count());
         else if (r < 75) send_word(ctb_pkg::CMD_LOAD, idx, pick_count());
         else             send_word(ctb_pkg::CMD_READ, idx, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
         counts[i]  = '0;
         repeats[i] = '0;
         queued[i]  = '0;
         tallies[i] = '0;
         armed[i]   = 1'b0;
      end
      reset           <= 1'b1;
      start           <= 1'b0;
      req_command     <= ctb_pkg::CMD_TICK;
      req_timer_index <= '0;
      req_value       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic();

      start <= 1'b0;
      while (timer_words_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (timer_words_due.size() != 0) begin
         mismatches++;
         $display("%0d expected words never arrived", timer_words_due.size());
      end
      $display("Covered %0d ticks, %0d adds, %0d loads, %0d reads, %0d timer expiries",
               n_ticks, n_adds, n_loads, n_reads, n_expiries);
      $display("including queued loads, re-adds and multi-digit borrows");
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout");
      $display("Regression FAIL");
      $finish;
   end

endmodule
